[rtl/twbm_pkg.sv]
package twbm_pkg;

  localparam int unsigned CountWidth = 10;
  localparam logic [CountWidth-1:0] CountMax = 10'd1023;
  localparam logic [CountWidth-1:0] LineLengthReset = 10'd26;

  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [7:0] ContLow  = 8'd128;
  localparam logic [7:0] ContHigh = 8'd223;
  localparam logic [7:0] Lead2Low = 8'd192;
  localparam logic [7:0] Lead3Low = 8'd224;
  localparam logic [7:0] Lead4Low = 8'd240;
  localparam logic [7:0] LeadHigh = 8'd247;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  in_entity;
    logic [1:0]            cont_left;
  } wrap_state_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CharSpace) || (b == CharTab) || (b == CharLf) || (b == CharCr);
  endfunction

  function automatic logic [1:0] expected_cont(input logic [7:0] b);
    logic [1:0] n;
    if (b < Lead2Low || b > LeadHigh) begin
      n = 2'd0;
    end else if (b < Lead3Low) begin
      n = 2'd1;
    end else if (b < Lead4Low) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

[rtl/text_wrap_break_marker.sv]
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata[7:0] text_byte, s_tlast last_byte
// m_*      out  m_tvalid/m_tready  m_tdata[7:0] out_byte, m_tuser[0] break_before,
//                                  m_tlast out_last
// cfg_*    in   cfg_valid/cfg_ready cfg_data[9:0] line_length
//
// one byte per cycle sustained while the output is not stalled; each byte passes the
// input register, then the result register, and the break state updates as it moves between them
// reset clears valids, line state and sets line_length to 26
// output stall backs up through the input register into s_tready
module text_wrap_break_marker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] text_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic [0:0] m_tuser,    // [0] break_before
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_data    // [9:0] line_length
);
  import twbm_pkg::*;

  logic [CountWidth-1:0] line_length;
  wrap_state_t           state;
  wrap_state_t           state_next;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_brk;
  logic       out_last;

  logic       advance;
  logic       brk_next;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  twbm_step u_step (
    .state        (state),
    .line_length  (line_length),
    .text_byte    (in_byte),
    .last_byte    (in_last),
    .state_next   (state_next),
    .break_before (brk_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LineLengthReset;
    end else if (cfg_valid && cfg_ready) begin
      line_length <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // line state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= in_byte;
      out_brk  <= brk_next;
      out_last <= in_last;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_byte;
  assign m_tuser[0] = out_brk;
  assign m_tlast    = out_last;

endmodule

[rtl/twbm_step.sv]
module twbm_step (
  input  twbm_pkg::wrap_state_t           state,
  input  logic [twbm_pkg::CountWidth-1:0] line_length,
  input  logic [7:0]                      text_byte,
  input  logic                            last_byte,
  output twbm_pkg::wrap_state_t           state_next,
  output logic                            break_before
);
  import twbm_pkg::*;

  logic                  starts;
  logic [CountWidth-1:0] count_tmp;
  wrap_state_t           upd;

  always_comb begin
    starts    = 1'b1;
    upd       = state;
    count_tmp = state.count;
    break_before = 1'b0;

    if (state.in_entity) begin
      starts = 1'b0;
      if (text_byte == CharSemi) begin
        upd.in_entity = 1'b0;
      end
    end else if (state.cont_left != 2'd0) begin
      if (text_byte >= ContLow && text_byte <= ContHigh) begin
        starts = 1'b0;
        upd.cont_left = state.cont_left - 2'd1;
      end else begin
        upd.cont_left = 2'd0;
      end
    end

    if (starts) begin
      if (line_length != '0 && state.count >= line_length) begin
        break_before = 1'b1;
        count_tmp = '0;
      end
      if (count_tmp < CountMax) begin
        count_tmp = count_tmp + 1'b1;
      end
      if (text_byte == CharAmp) begin
        upd.in_entity = 1'b1;
      end else if (is_space(text_byte)) begin
        count_tmp = '0;
      end else begin
        upd.cont_left = expected_cont(text_byte);
      end
      upd.count = count_tmp;
    end

    // end of text clears the line state
    if (last_byte) begin
      state_next = '0;
    end else begin
      state_next = upd;
    end
  end

endmodule

[tb/sv/tb_text_wrap_break_marker.sv]
`timescale 1ns / 100ps

module tb_text_wrap_break_marker;
  import twbm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       brk;
    logic       is_last;
  } marked_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [0:0] m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_data = '0;

  // bytes still owed by the block, oldest first
  marked_byte_t marked_q[$];

  // break tracking as the block should hold it
  logic [9:0] line_len = LineLengthReset;
  logic [9:0] run_count = '0;
  logic       in_entity = 1'b0;
  logic [1:0] cont_left = '0;

  int errors = 0;
  int cycles = 0;
  int sent = 0;
  bit idle_on = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int rx_wait = 0;
  int rx_hold = 0;

  always #10 clk = ~clk;

  text_wrap_break_marker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void mark_break(input logic [7:0] b, input logic is_last);
    marked_byte_t m;
    logic         starts;
    m.data    = b;
    m.brk     = 1'b0;
    m.is_last = is_last;
    starts    = 1'b1;
    if (in_entity) begin
      starts = 1'b0;
      if (b == CharSemi) in_entity = 1'b0;
    end else if (cont_left != 2'd0) begin
      if (b >= ContLow && b <= ContHigh) begin
        starts    = 1'b0;
        cont_left = cont_left - 2'd1;
      end else begin
        cont_left = 2'd0;
      end
    end
    if (starts) begin
      if (line_len != '0 && run_count >= line_len) begin
        m.brk     = 1'b1;
        run_count = '0;
      end
      if (run_count < CountMax) run_count = run_count + 10'd1;
      if (b == CharAmp) begin
        in_entity = 1'b1;
      end else if (b == CharSpace || b == CharTab || b == CharLf || b == CharCr) begin
        run_count = '0;
      end else if (b >= Lead4Low && b <= LeadHigh) begin
        cont_left = 2'd3;
      end else if (b >= Lead3Low && b <= LeadHigh) begin
        cont_left = 2'd2;
      end else if (b >= Lead2Low && b <= LeadHigh) begin
        cont_left = 2'd1;
      end else begin
        cont_left = 2'd0;
      end
    end
    marked_q.push_back(m);
    if (is_last) begin
      run_count = '0;
      in_entity = 1'b0;
      cont_left = 2'd0;
    end
  endfunction

  // receiver: random stalls plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
      rx_hold  <= 0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      rx_hold   <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_wait  <= rand_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    marked_byte_t m;
    if (!rst && m_tvalid && m_tready) begin
      if (marked_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual byte %h", $time, m_tdata);
        errors++;
      end else begin
        m = marked_q.pop_front();
        if (m_tdata !== m.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, m.data, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== m.brk) begin
          $display("%0t: break_before expected %b actual %b (byte %h)",
                   $time, m.brk, m_tuser[0], m.data);
          errors++;
        end
        if (m_tlast !== m.is_last) begin
          $display("%0t: out_last expected %b actual %b", $time, m.is_last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout, %0d bytes outstanding", $time, marked_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = idle_on ? rand_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    mark_break(b, is_last);
    sent++;
  endtask

  task automatic send_text_byte(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 49) == 0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (marked_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_line_length(input logic [9:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    line_len = v;
  endtask

  // one character-ish token: printable bytes, whitespace, entities, utf-8 good and bad
  task automatic send_token();
    int r;
    int n;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      b = 8'($urandom_range(33, 126));
      if (b == CharAmp) b = "a";
      send_text_byte(b);
    end else if (r < 65) begin
      case ($urandom_range(0, 3))
        0: send_text_byte(CharSpace);
        1: send_text_byte(CharTab);
        2: send_text_byte(CharLf);
        default: send_text_byte(CharCr);
      endcase
    end else if (r < 73) begin
      send_text_byte(CharAmp);
      n = $urandom_range(0, 5);
      repeat (n) send_text_byte(8'($urandom_range(0, 255)));
      send_text_byte(CharSemi);
    end else if (r < 85) begin
      n = $urandom_range(1, 3);
      case (n)
        1: b = 8'($urandom_range(Lead2Low, Lead3Low - 1));
        2: b = 8'($urandom_range(Lead3Low, Lead4Low - 1));
        default: b = 8'($urandom_range(Lead4Low, LeadHigh));
      endcase
      send_text_byte(b);
      repeat (n) send_text_byte(8'($urandom_range(ContLow, ContHigh)));
    end else if (r < 92) begin
      send_text_byte(8'($urandom_range(Lead3Low, LeadHigh)));
      repeat ($urandom_range(0, 1)) send_text_byte(8'($urandom_range(ContLow, ContHigh)));
      send_text_byte(8'($urandom_range(0, 255)));
    end else begin
      send_text_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_text(input bit write_cfg, input logic [9:0] len,
                                  input int n_bytes);
    int target;
    if (write_cfg) set_line_length(len);
    target = sent + n_bytes;
    while (sent < target) send_token();
  endtask

  task automatic test_directed_chars();
    logic [7:0] seq[$] = {"a", "b", "c", "d", CharSpace, CharAmp, "x", CharSemi,
                          "e", "f", "g", 8'hE2, 8'h82, 8'hAC, 8'hC3, 8'h28,
                          8'hF0, 8'h90, 8'h80, 8'h80, 8'hFF, 8'h00, CharTab,
                          CharLf, CharCr, CharSemi, CharAmp, "q"};
    set_line_length(10'd3);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
    // short text after a text end inside an entity
    send_byte("h", 1'b0);
    send_byte("i", 1'b1);
  endtask

  task automatic test_mid_text_change();
    set_line_length(10'd6);
    repeat (8) send_byte("k", 1'b0);
    set_line_length(10'd1);
    send_byte("x", 1'b0);
    send_byte("y", 1'b0);
    send_byte("z", 1'b1);
  endtask

  task automatic test_output_backpressure();
    int target;
    set_line_length(10'd4);
    idle_on = 1'b0;
    hold_seq <= hold_seq + 1;
    target = sent + 60;
    while (sent < target) send_token();
    idle_on = 1'b1;
    drain();
    target = sent + 20;
    while (sent < target) send_token();
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    test_random_text(1'b1, 10'($urandom_range(2, 12)), 60);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_random_text(1'b0, LineLengthReset, 150);
    test_directed_chars();
    test_mid_text_change();
    test_output_backpressure();
    test_random_text(1'b1, 10'd1, 70);
    test_random_text(1'b1, 10'd0, 70);
    test_random_text(1'b1, 10'd1023, 50);
    test_random_text(1'b1, 10'($urandom_range(2, 8)), 60);
    test_random_text(1'b1, 10'($urandom_range(9, 40)), 60);
    test_no_idle_stretch();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
